/* hdl/integer_stack_engine_with_pairs_macros.svh */
// ----------------------------------------------------------------------------
// integer stack engine assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef INTEGER_STACK_ENGINE_WITH_PAIRS_MACROS_SVH
`define INTEGER_STACK_ENGINE_WITH_PAIRS_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define ISE_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ise assertion failed");

// antecedent implies consequent in the following cycle
`define ISE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ise assertion failed");

`else

`define ISE_ASSERT_HOLDS(label, ante, cons)
`define ISE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/ise_pkg.sv */
// ----------------------------------------------------------------------------
// ise_pkg
// shared types, codes and defaults of the integer stack engine
// ----------------------------------------------------------------------------
package ise_pkg;

    localparam int DEF_STACK_WORDS = 1024;
    localparam int DEF_PAGE_WORDS  = 64;
    localparam int WORD_BITS       = 32;
    localparam int PAIR_BITS       = 2 * WORD_BITS;
    localparam int KIND_W          = 4;
    localparam int POS_W           = 10;
    localparam int COUNT_W         = 11;
    localparam int DEPTH_W         = 11;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_PUSH  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_TOP   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_RESV  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_GET   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SET   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_PPUSH = 4'd6;
    localparam logic [KIND_W-1:0] KIND_PPOP  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_PTOP  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_PGET  = 4'd9;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_FULL  = 2'd2,
        ERR_RANGE = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SECOND,
        S_PAIR2,
        S_RDW,
        S_FILL,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        A_TOP,
        A_TOP_M1,
        A_TOP_M2,
        A_POS,
        A_POS_P1,
        A_CLR
    } addr_sel_t;

    typedef enum logic [1:0] {
        W_LO,
        W_HI,
        W_ZERO
    } wsel_t;

    typedef enum logic [1:0] {
        T_HOLD,
        T_INC,
        T_DEC1,
        T_DEC2
    } top_op_t;

    typedef enum logic [1:0] {
        C_NONE,
        C_WORD,
        C_HI,
        C_LO
    } cap_t;

    typedef struct packed {
        logic      in_ready;
        logic      load_item;
        logic      clr_step;
        logic      we;
        addr_sel_t addr_sel;
        wsel_t     wdata_sel;
        top_op_t   top_op;
        cap_t      cap;
        logic      cnt_dec;
        logic      load_err;
        logic      load_out;
    } cmd_t;

    typedef struct packed {
        logic              in_valid;
        logic              clear_last;
        logic [KIND_W-1:0] kind;
        err_t              err;
        logic              pset;
        logic              cnt_zero;
        logic              cnt_one;
        logic              out_busy;
    } stat_t;

endpackage

/* hdl/ise_in_if.sv */
// ----------------------------------------------------------------------------
// ise_in_if
// operation channel: valid/ready handshake carrying one stack operation
// ----------------------------------------------------------------------------
interface ise_in_if
    import ise_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [PAIR_BITS-1:0] value;
    logic [POS_W-1:0]          position;
    logic [COUNT_W-1:0]        slot_count;
    logic                      pair_set;

    modport source (
        output valid, kind, value, position, slot_count, pair_set,
        input  ready
    );

    modport sink (
        input  valid, kind, value, position, slot_count, pair_set,
        output ready
    );
endinterface

/* hdl/ise_out_if.sv */
// ----------------------------------------------------------------------------
// ise_out_if
// result channel: valid/ready handshake carrying one operation result
// ----------------------------------------------------------------------------
interface ise_out_if
    import ise_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [PAIR_BITS-1:0] data;
    logic [1:0]                  error;
    logic                        empty_res;
    logic [DEPTH_W-1:0]          depth;

    modport source (
        output valid, data, error, empty_res, depth,
        input  ready
    );

    modport sink (
        input  valid, data, error, empty_res, depth,
        output ready
    );
endinterface

/* hdl/ise_ram.sv */
// ----------------------------------------------------------------------------
// ise_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module ise_ram
    import ise_pkg::*;
#(
    parameter int WIDTH = WORD_BITS,
    parameter int DEPTH = DEF_STACK_WORDS
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/ise_ctrl.sv */
// ----------------------------------------------------------------------------
// ise_ctrl
// sequencer for clearing, operation steps and result hand-off
// ----------------------------------------------------------------------------
module ise_ctrl
    import ise_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if (stat.err == ERR_OK)
                begin
                    case (stat.kind)
                        KIND_POP, KIND_TOP, KIND_GET: state_next = S_RDW;
                        KIND_RESV:
                        begin
                            if (!stat.cnt_zero)
                            begin
                                state_next = S_FILL;
                            end
                        end
                        KIND_PPUSH:                   state_next = S_SECOND;
                        KIND_PPOP, KIND_PTOP:         state_next = S_PAIR2;
                        KIND_PGET:
                        begin
                            state_next = stat.pset ? S_SECOND : S_PAIR2;
                        end
                        default:                      state_next = S_DONE;
                    endcase
                end
            end
            S_SECOND: state_next = S_DONE;
            S_PAIR2:  state_next = S_RDW;
            S_RDW:    state_next = S_DONE;
            S_FILL:
            begin
                if (stat.cnt_one)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.in_ready  = 1'b0;
        cmd.load_item = 1'b0;
        cmd.clr_step  = 1'b0;
        cmd.we        = 1'b0;
        cmd.addr_sel  = A_TOP;
        cmd.wdata_sel = W_LO;
        cmd.top_op    = T_HOLD;
        cmd.cap       = C_NONE;
        cmd.cnt_dec   = 1'b0;
        cmd.load_err  = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step  = 1'b1;
                cmd.we        = 1'b1;
                cmd.addr_sel  = A_CLR;
                cmd.wdata_sel = W_ZERO;
            end
            S_IDLE:
            begin
                cmd.in_ready  = 1'b1;
                cmd.load_item = stat.in_valid;
            end
            S_EXEC:
            begin
                cmd.load_err = 1'b1;
                if (stat.err == ERR_OK)
                begin
                    case (stat.kind)
                        KIND_PUSH:
                        begin
                            cmd.we     = 1'b1;
                            cmd.top_op = T_INC;
                        end
                        KIND_POP, KIND_TOP:   cmd.addr_sel = A_TOP_M1;
                        KIND_GET:             cmd.addr_sel = A_POS;
                        KIND_SET:
                        begin
                            cmd.we       = 1'b1;
                            cmd.addr_sel = A_POS;
                        end
                        KIND_PPUSH:
                        begin
                            cmd.we        = 1'b1;
                            cmd.wdata_sel = W_HI;
                            cmd.top_op    = T_INC;
                        end
                        KIND_PPOP, KIND_PTOP: cmd.addr_sel = A_TOP_M2;
                        KIND_PGET:
                        begin
                            cmd.addr_sel  = A_POS;
                            cmd.we        = stat.pset;
                            cmd.wdata_sel = W_HI;
                        end
                        default: ;
                    endcase
                end
            end
            S_SECOND:
            begin
                // low word of a pair write
                cmd.we = 1'b1;
                if (stat.kind == KIND_PPUSH)
                begin
                    cmd.top_op = T_INC;
                end
                else
                begin
                    cmd.addr_sel = A_POS_P1;
                end
            end
            S_PAIR2:
            begin
                cmd.cap      = C_HI;
                cmd.addr_sel = (stat.kind == KIND_PGET) ? A_POS_P1 : A_TOP_M1;
            end
            S_RDW:
            begin
                case (stat.kind)
                    KIND_POP:
                    begin
                        cmd.cap    = C_WORD;
                        cmd.top_op = T_DEC1;
                    end
                    KIND_TOP, KIND_GET: cmd.cap = C_WORD;
                    KIND_PPOP:
                    begin
                        cmd.cap    = C_LO;
                        cmd.top_op = T_DEC2;
                    end
                    default:            cmd.cap = C_LO;
                endcase
            end
            S_FILL:
            begin
                cmd.we        = 1'b1;
                cmd.wdata_sel = W_ZERO;
                cmd.top_op    = T_INC;
                cmd.cnt_dec   = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = !stat.out_busy;
            end
            default: ;
        endcase
    end

endmodule

/* hdl/ise_dpath.sv */
// ----------------------------------------------------------------------------
// ise_dpath
// stack pointer, page limit, word store, error check and result registers
// ----------------------------------------------------------------------------
module ise_dpath
    import ise_pkg::*;
#(
    parameter int STACK_WORDS = DEF_STACK_WORDS,
    parameter int PAGE_WORDS  = DEF_PAGE_WORDS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output stat_t      stat,
    ise_in_if.sink     req,
    ise_out_if.source  rsp
);

    localparam int AW    = $clog2(STACK_WORDS);
    localparam int PTR_W = $clog2(STACK_WORDS + 1);
    localparam int LIM_W = $clog2(STACK_WORDS + PAGE_WORDS);
    localparam int CW    = (LIM_W > 12) ? LIM_W : 12;

    // control state
    logic [PTR_W-1:0] top_reg;
    logic [PTR_W-1:0] top_next;
    logic [LIM_W-1:0] limit_reg;
    logic [LIM_W-1:0] limit_next;
    logic [AW-1:0]    clr_reg;
    logic             out_valid_reg;

    // latched transaction and working values
    logic [KIND_W-1:0]    kind_reg;
    logic [PAIR_BITS-1:0] value_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [COUNT_W-1:0]   cnt_next;
    logic                 pset_reg;
    logic [PAIR_BITS-1:0] data_reg;
    logic [PAIR_BITS-1:0] data_next;
    err_t                 err_reg;

    // result register
    logic [PAIR_BITS-1:0] out_data_reg;
    err_t                 out_err_reg;
    logic                 out_empty_reg;
    logic [DEPTH_W-1:0]   out_depth_reg;

    logic [CW-1:0]        top_c;
    logic [CW-1:0]        lim_c;
    logic [CW-1:0]        stack_c;
    logic [CW-1:0]        free_c;
    logic [CW-1:0]        pos_c;
    logic [CW-1:0]        pos1_c;
    logic [CW-1:0]        cnt_c;
    logic                 pos_ok;
    logic                 pos1_ok;
    logic [PTR_W-1:0]     top_inc;
    err_t                 err_code;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    assign top_c   = CW'(top_reg);
    assign lim_c   = CW'(limit_reg);
    assign stack_c = CW'(STACK_WORDS);
    assign free_c  = stack_c - top_c;
    assign pos_c   = CW'(pos_reg);
    assign pos1_c  = pos_c + CW'(1);
    assign cnt_c   = CW'(cnt_reg);
    assign pos_ok  = (pos_c < lim_c) && (pos_c < stack_c);
    assign pos1_ok = (pos1_c < lim_c) && (pos1_c < stack_c);
    assign top_inc = top_reg + PTR_W'(1);

    always_comb
    begin
        err_code = ERR_OK;
        case (kind_reg)
            KIND_PUSH:
            begin
                if (top_c == stack_c)
                begin
                    err_code = ERR_FULL;
                end
            end
            KIND_POP, KIND_TOP:
            begin
                if (top_c == '0)
                begin
                    err_code = ERR_UNDER;
                end
            end
            KIND_RESV:
            begin
                if (cnt_c > free_c)
                begin
                    err_code = ERR_FULL;
                end
            end
            KIND_GET, KIND_SET:
            begin
                if (!pos_ok)
                begin
                    err_code = ERR_RANGE;
                end
            end
            KIND_PPUSH:
            begin
                if (free_c < CW'(2))
                begin
                    err_code = ERR_FULL;
                end
            end
            KIND_PPOP, KIND_PTOP:
            begin
                if (top_c < CW'(2))
                begin
                    err_code = ERR_UNDER;
                end
            end
            KIND_PGET:
            begin
                if (!pos_ok || !pos1_ok)
                begin
                    err_code = ERR_RANGE;
                end
            end
            default: ;
        endcase
    end

    // pointer and page limit; pushes move the top by one, so one page step suffices
    always_comb
    begin
        top_next   = top_reg;
        limit_next = limit_reg;
        case (cmd.top_op)
            T_INC:
            begin
                top_next = top_inc;
                if (CW'(top_inc) > lim_c)
                begin
                    limit_next = limit_reg + LIM_W'(PAGE_WORDS);
                end
            end
            T_DEC1:  top_next = top_reg - PTR_W'(1);
            T_DEC2:  top_next = top_reg - PTR_W'(2);
            default: ;
        endcase
    end

    always_comb
    begin
        case (cmd.addr_sel)
            A_TOP:    mem_addr = AW'(top_reg);
            A_TOP_M1: mem_addr = AW'(top_reg - PTR_W'(1));
            A_TOP_M2: mem_addr = AW'(top_reg - PTR_W'(2));
            A_POS:    mem_addr = AW'(pos_c);
            A_POS_P1: mem_addr = AW'(pos1_c);
            A_CLR:    mem_addr = clr_reg;
            default:  mem_addr = clr_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wdata_sel)
            W_LO:    mem_wdata = value_reg[WORD_BITS-1:0];
            W_HI:    mem_wdata = value_reg[PAIR_BITS-1:WORD_BITS];
            default: mem_wdata = '0;
        endcase
    end

    always_comb
    begin
        data_next = data_reg;
        if (cmd.load_item)
        begin
            data_next = '0;
        end
        else
        begin
            case (cmd.cap)
                C_WORD: data_next = {{WORD_BITS{mem_rdata[WORD_BITS-1]}}, mem_rdata};
                C_HI:   data_next = {mem_rdata, data_reg[WORD_BITS-1:0]};
                C_LO:   data_next = {data_reg[PAIR_BITS-1:WORD_BITS], mem_rdata};
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load_item)
        begin
            cnt_next = req.slot_count;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            limit_reg     <= LIM_W'(PAGE_WORDS);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg   <= top_next;
            limit_reg <= limit_next;
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg  <= req.kind;
            value_reg <= req.value;
            pos_reg   <= req.position;
            pset_reg  <= req.pair_set;
        end
        cnt_reg  <= cnt_next;
        data_reg <= data_next;
        if (cmd.load_err)
        begin
            err_reg <= err_code;
        end
        if (cmd.load_out)
        begin
            out_data_reg  <= data_reg;
            out_err_reg   <= err_reg;
            out_empty_reg <= (top_reg == '0);
            out_depth_reg <= DEPTH_W'(top_reg);
        end
    end

    ise_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STACK_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign req.ready = cmd.in_ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.data      = out_data_reg;
    assign rsp.error     = out_err_reg;
    assign rsp.empty_res = out_empty_reg;
    assign rsp.depth     = out_depth_reg;

    assign stat.in_valid   = req.valid;
    assign stat.clear_last = (clr_reg == AW'(STACK_WORDS - 1));
    assign stat.kind       = kind_reg;
    assign stat.err        = err_code;
    assign stat.pset       = pset_reg;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.cnt_one    = (cnt_reg == COUNT_W'(1));
    assign stat.out_busy   = out_valid_reg && !rsp.ready;

endmodule

/* hdl/integer_stack_engine_with_pairs.sv */
// ----------------------------------------------------------------------------
// integer_stack_engine_with_pairs
// 32-bit operand stack with page accounting, word and pair operations
// ----------------------------------------------------------------------------
//  channel  modport  carries
//  req      sink     kind, value, position, slot_count, pair_set
//  rsp      source   data, error, empty_res, depth
//
//  steps: accept, execute, hand-off; reads add a read-data step, pair
//  operations a second word access, a reserve of n slots a fill step per
//  slot, errors and no-ops none; the single port of the word store sets this
//  after reset the store is zeroed one word a cycle, all STACK_WORDS words,
//  with req.ready held low
//  a result held in the output register stalls only the final step
// ----------------------------------------------------------------------------
`include "integer_stack_engine_with_pairs_macros.svh"

module integer_stack_engine_with_pairs
    import ise_pkg::*;
#(
    parameter int STACK_WORDS = DEF_STACK_WORDS,
    parameter int PAGE_WORDS  = DEF_PAGE_WORDS
)
(
    input  logic      clk,
    input  logic      rst_n,
    ise_in_if.sink    req,
    ise_out_if.source rsp
);

    cmd_t  cmd;
    stat_t stat;

    ise_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    ise_dpath #(
        .STACK_WORDS (STACK_WORDS),
        .PAGE_WORDS  (PAGE_WORDS)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

    `ISE_ASSERT_HOLDS(a_no_accept_while_clearing, cmd.clr_step, !req.ready)
    `ISE_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready)
    `ISE_ASSERT_HOLDS(a_empty_matches_depth, rsp.valid, rsp.empty_res == (rsp.depth == 11'd0))
    `ISE_ASSERT_HOLDS(a_error_carries_no_data, rsp.valid && (rsp.error != ERR_OK), rsp.data == '0)

endmodule

/* tb/integer_stack_engine_with_pairs_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_stack_engine_with_pairs_test
// drives word, pair, reserve and absolute-access operations into the stack
// engine and checks every result transaction against a behavioural stack
// ----------------------------------------------------------------------------
module integer_stack_engine_with_pairs_test
    import ise_pkg::*;
;

    localparam int STK_WORDS    = DEF_STACK_WORDS;
    localparam int PG_WORDS     = DEF_PAGE_WORDS;
    localparam int RANDOM_OPS   = 1325;
    localparam int TAIL_CYCLES  = 50;
    localparam int RUN_LIMIT_NS = 50_000_000;

    // kinds from here up are ignored by the engine
    localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 4'd10;
    localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 4'd15;

    typedef enum int {PH_GROW, PH_SHRINK, PH_ACCESS, PH_MIXED} phase_t;
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [PAIR_BITS-1:0] value;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   slot_count;
        logic                 pair_set;
        bit                   drain;    // hold back until all results are in
    } stack_op_t;

    typedef struct {
        logic [PAIR_BITS-1:0] data;
        err_t                 err;
        logic                 empty_res;
        logic [DEPTH_W-1:0]   depth;
    } stack_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ise_in_if  req_if ();
    ise_out_if rsp_if ();

    integer_stack_engine_with_pairs u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // behavioural stack state
    logic [WORD_BITS-1:0] stack_mem [STK_WORDS];
    int                   stk_top;
    int                   page_cnt;
    int                   peak_depth;
    int                   err_tally [4];

    stack_op_t     op_queue [$];
    stack_result_t awaited_results [$];
    stack_op_t     cur_op;
    stack_result_t got_ref;

    int  total_ops;
    int  ops_accepted;
    int  results_seen;
    int  mismatch_cnt;
    int  burst_left;
    int  gap_left;
    bit  send_valid;

    int         sink_cyc;
    sink_mode_t sink_mode;

    // stimulus shaping only: rough depth and page count as queued
    int     gen_depth;
    int     gen_pages;
    bit     drain_next;

    function automatic logic [PAIR_BITS-1:0] widen_word(logic [WORD_BITS-1:0] w);
        return {{WORD_BITS{w[WORD_BITS-1]}}, w};
    endfunction

    function automatic void push_onto_stack(logic [WORD_BITS-1:0] w);
        int need;
        stack_mem[stk_top] = w;
        stk_top++;
        need = (stk_top + PG_WORDS - 1) / PG_WORDS;
        if (need > page_cnt)
            page_cnt = need;
        if (stk_top > peak_depth)
            peak_depth = stk_top;
    endfunction

    function automatic bit slot_inside(int pos);
        return pos < page_cnt * PG_WORDS && pos < STK_WORDS;
    endfunction

    function automatic stack_result_t stack_apply(stack_op_t op);
        stack_result_t        r;
        logic [WORD_BITS-1:0] lo_w;
        logic [WORD_BITS-1:0] hi_w;
        int                   room;
        r.data = '0;
        r.err  = ERR_OK;
        lo_w   = op.value[WORD_BITS-1:0];
        hi_w   = op.value[PAIR_BITS-1:WORD_BITS];
        room   = STK_WORDS - stk_top;
        case (op.kind)
            KIND_PUSH:
                if (room < 1)
                    r.err = ERR_FULL;
                else
                    push_onto_stack(lo_w);
            KIND_POP, KIND_TOP:
                if (stk_top == 0)
                    r.err = ERR_UNDER;
                else
                begin
                    r.data = widen_word(stack_mem[stk_top-1]);
                    if (op.kind == KIND_POP)
                        stk_top--;
                end
            KIND_RESV:
                if (op.slot_count > room)
                    r.err = ERR_FULL;
                else
                    for (int n = 0; n < op.slot_count; n++)
                        push_onto_stack('0);
            KIND_GET:
                if (!slot_inside(op.position))
                    r.err = ERR_RANGE;
                else
                    r.data = widen_word(stack_mem[op.position]);
            KIND_SET:
                if (!slot_inside(op.position))
                    r.err = ERR_RANGE;
                else
                    stack_mem[op.position] = lo_w;
            KIND_PPUSH:
                if (room < 2)
                    r.err = ERR_FULL;
                else
                begin
                    push_onto_stack(hi_w);
                    push_onto_stack(lo_w);
                end
            KIND_PPOP, KIND_PTOP:
                if (stk_top < 2)
                    r.err = ERR_UNDER;
                else
                begin
                    // high word sits deeper
                    r.data = {stack_mem[stk_top-2], stack_mem[stk_top-1]};
                    if (op.kind == KIND_PPOP)
                        stk_top -= 2;
                end
            KIND_PGET:
                if (!slot_inside(op.position) || !slot_inside(int'(op.position) + 1))
                    r.err = ERR_RANGE;
                else if (op.pair_set)
                begin
                    stack_mem[op.position]     = hi_w;
                    stack_mem[op.position + 1] = lo_w;
                end
                else
                    r.data = {stack_mem[op.position], stack_mem[op.position + 1]};
            default:
                ;
        endcase
        r.empty_res = (stk_top == 0);
        r.depth     = DEPTH_W'(stk_top);
        err_tally[r.err]++;
        return r;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid      <= 1'b0;
            req_if.kind       <= KIND_PUSH;
            req_if.value      <= '0;
            req_if.position   <= '0;
            req_if.slot_count <= '0;
            req_if.pair_set   <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            send_valid = req_if.valid;
            if (req_if.valid && req_if.ready)
            begin
                awaited_results.push_back(stack_apply(cur_op));
                ops_accepted++;
                send_valid = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 16);
                end
            end
            if (!send_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (op_queue.size() != 0 &&
                         !(op_queue[0].drain && awaited_results.size() != 0))
                begin
                    cur_op = op_queue.pop_front();
                    req_if.kind       <= cur_op.kind;
                    req_if.value      <= cur_op.value;
                    req_if.position   <= cur_op.position;
                    req_if.slot_count <= cur_op.slot_count;
                    req_if.pair_set   <= cur_op.pair_set;
                    send_valid = 1'b1;
                end
            end
            req_if.valid <= send_valid;
        end
    end

    // receiver: stall pattern is drawn anew at random from four modes on sink_cyc boundaries
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            sink_cyc     <= 0;
            sink_mode    <= SINK_OPEN;
        end
        else
        begin
            sink_cyc <= sink_cyc + 1;
            if (sink_cyc % 128 == 0)
                sink_mode <= sink_mode_t'($urandom_range(0, 3));
            case (sink_mode)
                SINK_OPEN:     rsp_if.ready <= 1'b1;
                SINK_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
                SINK_PERIODIC: rsp_if.ready <= (sink_cyc % 5) >= 3;
                default:       rsp_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                mismatch_cnt++;
            end
            else
            begin
                got_ref = awaited_results.pop_front();
                if (rsp_if.data !== got_ref.data)
                begin
                    $error("data: expected %h, actual %h", got_ref.data, rsp_if.data);
                    mismatch_cnt++;
                end
                if (rsp_if.error !== got_ref.err)
                begin
                    $error("error: expected %0d, actual %0d", got_ref.err, rsp_if.error);
                    mismatch_cnt++;
                end
                if (rsp_if.empty_res !== got_ref.empty_res)
                begin
                    $error("empty_res: expected %0d, actual %0d",
                           got_ref.empty_res, rsp_if.empty_res);
                    mismatch_cnt++;
                end
                if (rsp_if.depth !== got_ref.depth)
                begin
                    $error("depth: expected %0d, actual %0d", got_ref.depth, rsp_if.depth);
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic queue_op(input logic [KIND_W-1:0] k, input logic [PAIR_BITS-1:0] v,
                            input logic [POS_W-1:0] p, input logic [COUNT_W-1:0] c,
                            input logic ps);
        stack_op_t op;
        int        need;
        op.kind       = k;
        op.value      = v;
        op.position   = p;
        op.slot_count = c;
        op.pair_set   = ps;
        op.drain      = drain_next;
        drain_next    = 1'b0;
        op_queue.push_back(op);
        case (k)
            KIND_PUSH:  if (gen_depth < STK_WORDS) gen_depth++;
            KIND_POP:   if (gen_depth > 0) gen_depth--;
            KIND_RESV:  if (c <= STK_WORDS - gen_depth) gen_depth += c;
            KIND_PPUSH: if (gen_depth <= STK_WORDS - 2) gen_depth += 2;
            KIND_PPOP:  if (gen_depth >= 2) gen_depth -= 2;
            default:    ;
        endcase
        need = (gen_depth + PG_WORDS - 1) / PG_WORDS;
        if (need > gen_pages)
            gen_pages = need;
    endtask

    function automatic logic [PAIR_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            4:       return {$urandom, 32'h8000_0000 | $urandom_range(0, 255)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int lim;
        int roll;
        int p;
        lim  = (gen_pages * PG_WORDS > STK_WORDS) ? STK_WORDS : gen_pages * PG_WORDS;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            p = $urandom_range(0, lim - 1);
        else if (roll < 7)
            p = gen_depth - 2 + $urandom_range(0, 3);
        else if (roll < 8)
            p = lim - $urandom_range(0, 1);
        else
            p = $urandom_range(0, STK_WORDS - 1);
        if (p < 0)
            p = 0;
        if (p > STK_WORDS - 1)
            p = STK_WORDS - 1;
        return POS_W'(p);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int room;
        int roll;
        room = STK_WORDS - gen_depth;
        roll = $urandom_range(0, 19);
        if (roll < 10)
            return COUNT_W'($urandom_range(0, 4));
        else if (roll < 14)
            return COUNT_W'($urandom_range(5, 70));
        else if (roll < 16)
            // fill exactly if room is at most 200
            return (room <= 200) ? COUNT_W'(room) : COUNT_W'($urandom_range(0, 8));
        else if (roll < 17)
            // one too many, unless the stack is empty
            return (room < STK_WORDS) ? COUNT_W'(room + 1) : COUNT_W'(STK_WORDS);
        else if (roll < 18)
            return COUNT_W'(STK_WORDS);
        else
            return COUNT_W'($urandom_range(0, STK_WORDS));
    endfunction

    function automatic logic [KIND_W-1:0] choose_kind(phase_t ph);
        int roll;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_GROW:
                if (roll < 35)      return KIND_PUSH;
                else if (roll < 55) return KIND_PPUSH;
                else if (roll < 70) return KIND_RESV;
                else if (roll < 78) return KIND_POP;
                else if (roll < 84) return KIND_SET;
                else if (roll < 90) return KIND_GET;
                else if (roll < 95) return KIND_PGET;
                else                return KIND_TOP;
            PH_SHRINK:
                if (roll < 30)      return KIND_POP;
                else if (roll < 55) return KIND_PPOP;
                else if (roll < 65) return KIND_TOP;
                else if (roll < 75) return KIND_PTOP;
                else if (roll < 82) return KIND_PUSH;
                else if (roll < 88) return KIND_GET;
                else if (roll < 94) return KIND_PGET;
                else                return KIND_RESV;
            PH_ACCESS:
                if (roll < 25)      return KIND_GET;
                else if (roll < 50) return KIND_SET;
                else if (roll < 80) return KIND_PGET;
                else if (roll < 85) return KIND_PUSH;
                else if (roll < 90) return KIND_POP;
                else if (roll < 95) return KIND_PPUSH;
                else                return KIND_PTOP;
            default:
                return KIND_W'($urandom_range(0, 15));
        endcase
    endfunction

    initial
    begin
        phase_t            ph;
        int                seg_left;
        int                counted;
        int                next_drain;
        logic [KIND_W-1:0] k;

        req_if.valid      = 1'b0;
        req_if.kind       = KIND_PUSH;
        req_if.value      = '0;
        req_if.position   = '0;
        req_if.slot_count = '0;
        req_if.pair_set   = 1'b0;
        rsp_if.ready      = 1'b0;

        foreach (stack_mem[i])
            stack_mem[i] = '0;
        stk_top    = 0;
        page_cnt   = 1;
        peak_depth = 0;
        gen_depth  = 0;
        gen_pages  = 1;
        drain_next = 1'b0;

        // directed: empty stack, page edges, sign handling, full store
        queue_op(KIND_POP,   '0, '0, '0, 1'b0);
        queue_op(KIND_PPOP,  '0, '0, '0, 1'b0);
        queue_op(KIND_GET,   '0, 10'd0, '0, 1'b0);
        queue_op(KIND_GET,   '0, 10'd64, '0, 1'b0);
        queue_op(KIND_SET,   64'h0123_4567_8000_0000, 10'd63, '0, 1'b0);
        queue_op(KIND_GET,   '0, 10'd63, '0, 1'b0);
        queue_op(KIND_PGET,  '0, 10'd63, '0, 1'b0);
        queue_op(KIND_PGET,  64'h7FFF_FFFF_FFFF_FFFF, 10'd62, '0, 1'b1);
        queue_op(KIND_PGET,  '0, 10'd62, '0, 1'b0);
        queue_op(KIND_PUSH,  64'h8000_0000_0000_0000, '0, '0, 1'b0);
        queue_op(KIND_PUSH,  '1, '0, '0, 1'b0);
        queue_op(KIND_TOP,   '0, '0, '0, 1'b0);
        queue_op(KIND_POP,   '0, '0, '0, 1'b0);
        queue_op(KIND_PPUSH, 64'h8000_0000_FFFF_FFFF, '0, '0, 1'b0);
        queue_op(KIND_PTOP,  '0, '0, '0, 1'b0);
        queue_op(KIND_PPOP,  '0, '0, '0, 1'b0);
        queue_op(KIND_PPOP,  '0, '0, '0, 1'b0);
        queue_op(KIND_RESV,  '0, '0, 11'd0, 1'b0);
        queue_op(KIND_RESV,  '0, '0, 11'd1024, 1'b0);
        queue_op(KIND_RESV,  '0, '0, 11'd1023, 1'b0);
        queue_op(KIND_PUSH,  '1, '0, '0, 1'b0);
        queue_op(KIND_PPUSH, '1, '0, '0, 1'b0);
        queue_op(KIND_PGET,  '0, 10'd1023, '0, 1'b0);
        queue_op(KIND_FIRST_UNUSED, '1, '1, '1, 1'b1);
        queue_op(KIND_LAST_UNUSED,  '0, '0, '0, 1'b0);

        // random: phases of growth, shrinkage, absolute access and noise
        drain_next = 1'b1;
        counted    = 0;
        seg_left   = 0;
        next_drain = 450;
        ph         = PH_SHRINK;
        while (counted < RANDOM_OPS)
        begin
            if (seg_left == 0)
            begin
                ph       = phase_t'($urandom_range(0, 3));
                seg_left = $urandom_range(15, 60);
            end
            if (counted >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain += 450;
            end
            k = choose_kind(ph);
            queue_op(k, pick_value(), pick_position(), pick_count(),
                     1'($urandom_range(0, 1)));
            counted++;
            seg_left--;
        end
        total_ops = op_queue.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_accepted < total_ops || awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d operations, %0d results checked, peak depth %0d, %0d pages in use",
                 ops_accepted, results_seen, peak_depth, page_cnt);
        $display("outcomes: %0d ok, %0d underflow, %0d full, %0d out of range",
                 err_tally[ERR_OK], err_tally[ERR_UNDER], err_tally[ERR_FULL],
                 err_tally[ERR_RANGE]);
        if (mismatch_cnt == 0)
            $display("** integer_stack_engine_with_pairs: PASSED **");
        else
            $display("** integer_stack_engine_with_pairs: FAILED **");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d of %0d operations accepted, %0d results outstanding",
                 ops_accepted, total_ops, awaited_results.size());
        $display("** integer_stack_engine_with_pairs: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/ise_pkg.sv
hdl/ise_in_if.sv
hdl/ise_out_if.sv
hdl/ise_ram.sv
hdl/ise_ctrl.sv
hdl/ise_dpath.sv
hdl/integer_stack_engine_with_pairs.sv
tb/integer_stack_engine_with_pairs_test.sv
